FILE: design/mesh_node_neighbor_finder_top_macros.svh
// ============================================================================
// Assertion macros for the mesh node neighbour finder
// Shorthands for clocked assertions on clk_i, disabled while rst_ni is low.
// ============================================================================
`ifndef MESH_NODE_NEIGHBOR_FINDER_TOP_MACROS_SVH
`define MESH_NODE_NEIGHBOR_FINDER_TOP_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define MNNF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define MNNF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define MNNF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mnnf_pkg.sv
// ============================================================================
// Mesh node neighbour finder package
// Field widths, operation codes, parameter defaults and the sequencer states.
// ============================================================================
package mnnf_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_TRIANGLES_DEF = 4096;
  localparam int unsigned MAX_NEIGHBORS_DEF = 16;
  localparam int unsigned NODE_BITS_DEF     = 16;

  // Fixed field widths of the request and result channels.
  localparam int unsigned SLOT_W       = 12;
  localparam int unsigned NODE_FIELD_W = 16;
  localparam int unsigned COUNT_W      = 13;

  // Request operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Query sequencer states.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_APPEND = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

endpackage

FILE: design/mnnf_in_if.sv
// ============================================================================
// Request channel
// Valid/ready channel carrying one load or query request.
// ============================================================================
interface mnnf_in_if;
  import mnnf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [SLOT_W-1:0]       slot;
  logic [NODE_FIELD_W-1:0] corner_a;
  logic [NODE_FIELD_W-1:0] corner_b;
  logic [NODE_FIELD_W-1:0] corner_c;
  logic [NODE_FIELD_W-1:0] query_node;

  modport source (
    output valid, op, slot, corner_a, corner_b, corner_c, query_node,
    input  ready
  );

  modport sink (
    input  valid, op, slot, corner_a, corner_b, corner_c, query_node,
    output ready
  );
endinterface

FILE: design/mnnf_out_if.sv
// ============================================================================
// Result channel
// Valid/ready channel carrying one neighbour result.
// ============================================================================
interface mnnf_out_if;
  import mnnf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [NODE_FIELD_W-1:0] neighbor;
  logic                    found;
  logic                    last;
  logic                    truncated;

  modport source (
    output valid, neighbor, found, last, truncated,
    input  ready
  );

  modport sink (
    input  valid, neighbor, found, last, truncated,
    output ready
  );
endinterface

FILE: design/mnnf_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with a registered read.
// ============================================================================
module mnnf_ram #(
  parameter int unsigned WIDTH  = 48,
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: design/mesh_node_neighbor_finder_top.sv
// ============================================================================
// Mesh node neighbour finder
// Holds a triangle table in RAM and lists the distinct neighbours of a node.
// ============================================================================
// Load request: the table entry is written at the accepting edge.
// Query request: the scanned triangle count is capped at MAX_TRIANGLES; the RAM
// reads one triangle a cycle while no hit is being captured or examined; a hit is
// captured, then each corner is checked and appended. Results then leave one a
// cycle unless out_rsp stalls; the next request is taken after the last one.
// Reset clears control state and the count register; table and list are not.
`include "mesh_node_neighbor_finder_top_macros.svh"

module mesh_node_neighbor_finder_top #(
  parameter int unsigned MAX_TRIANGLES = mnnf_pkg::MAX_TRIANGLES_DEF,
  parameter int unsigned MAX_NEIGHBORS = mnnf_pkg::MAX_NEIGHBORS_DEF,
  parameter int unsigned NODE_BITS     = mnnf_pkg::NODE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mnnf_in_if.sink                      in_req,
  mnnf_out_if.source                   out_rsp,
  input  logic                         cfg_we_i,
  input  logic [mnnf_pkg::COUNT_W-1:0] cfg_data_i
);
  import mnnf_pkg::*;

  localparam int unsigned NODE_W  = (NODE_BITS < NODE_FIELD_W) ? NODE_BITS : NODE_FIELD_W;
  localparam int unsigned TRI_W   = 3 * NODE_W;
  localparam int unsigned ADDR_W  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_TRIANGLES + 1);
  localparam int unsigned LIST_IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned TOT_W   = $clog2(MAX_NEIGHBORS + 1);

  // Control state.
  state_e             state_q, state_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0]   limit_q, limit_d;
  logic [CNT_W-1:0]   addr_q, addr_d;
  logic               pend_q, pend_d;
  logic [1:0]         corner_q, corner_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic               trunc_q, trunc_d;
  logic [TOT_W-1:0]   emit_q, emit_d;
  logic               out_valid_q, out_valid_d;

  // Payload state.
  logic [NODE_W-1:0]       node_q, node_d;
  logic [TRI_W-1:0]        tri_q, tri_d;
  logic [MAX_NEIGHBORS-1:0] dup_q, dup_d;
  logic                    self_q, self_d;
  logic [NODE_W-1:0]       list_q [MAX_NEIGHBORS];
  logic [NODE_W-1:0]       list_d [MAX_NEIGHBORS];
  logic [NODE_FIELD_W-1:0] out_neighbor_q, out_neighbor_d;
  logic                    out_found_q, out_found_d;
  logic                    out_last_q, out_last_d;
  logic                    out_trunc_q, out_trunc_d;

  // Datapath signals.
  logic              in_acc;
  logic              out_free;
  logic [31:0]       slot_ext;
  logic              wr_en;
  logic [TRI_W-1:0]  wr_data;
  logic              rd_en;
  logic [TRI_W-1:0]  rd_data;
  logic              tri_hit;
  logic [NODE_W-1:0] cur_v;
  logic              is_new;
  logic              emit_final;
  logic [TOT_W:0]    emit_next;

  // Handshakes.
  assign in_req.ready = (state_q == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_q || out_rsp.ready;

  // Triangle table writes; slots beyond the table are dropped.
  assign slot_ext = 32'(in_req.slot);
  assign wr_en    = in_acc && (in_req.op == OP_LOAD) && (slot_ext < 32'(MAX_TRIANGLES));
  assign wr_data  = {in_req.corner_c[NODE_W-1:0], in_req.corner_b[NODE_W-1:0],
                     in_req.corner_a[NODE_W-1:0]};

  // A triangle returned by the RAM holds the queried node.
  assign tri_hit = pend_q && ((rd_data[0 +: NODE_W] == node_q) ||
                              (rd_data[NODE_W +: NODE_W] == node_q) ||
                              (rd_data[2*NODE_W +: NODE_W] == node_q));

  // Reads stop while a hit is captured and its corners are examined, so none is lost.
  assign rd_en = (state_q == S_SCAN) && !tri_hit && (addr_q < limit_q);

  mnnf_ram #(
    .WIDTH  (TRI_W),
    .DEPTH  (MAX_TRIANGLES),
    .ADDR_W (ADDR_W)
  ) u_tri_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot_ext[ADDR_W-1:0]),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (addr_q[ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  // Corner of the captured triangle under examination.
  always_comb begin
    case (corner_q)
      2'd0:    cur_v = tri_q[0 +: NODE_W];
      2'd1:    cur_v = tri_q[NODE_W +: NODE_W];
      default: cur_v = tri_q[2*NODE_W +: NODE_W];
    endcase
  end

  // Duplicate search against every valid list entry.
  always_comb begin
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      dup_d[i] = (list_q[i] == cur_v) && (TOT_W'(i) < total_q);
    end
  end

  assign is_new     = !self_q && !(|dup_q);
  assign emit_next  = {1'b0, emit_q} + 1'b1;
  assign emit_final = (total_q == '0) || (emit_next == {1'b0, total_q});

  // Scan limit, capped at the table depth.
  assign limit_d = (32'(count_q) > 32'(MAX_TRIANGLES)) ? CNT_W'(MAX_TRIANGLES)
                                                       : CNT_W'(count_q);

  // Query sequencer.
  always_comb begin
    state_d        = state_q;
    count_d        = cfg_we_i ? cfg_data_i : count_q;
    addr_d         = addr_q;
    pend_d         = pend_q;
    corner_d       = corner_q;
    total_d        = total_q;
    trunc_d        = trunc_q;
    emit_d         = emit_q;
    out_valid_d    = out_valid_q && !out_rsp.ready;
    node_d         = node_q;
    tri_d          = tri_q;
    self_d         = self_q;
    list_d         = list_q;
    out_neighbor_d = out_neighbor_q;
    out_found_d    = out_found_q;
    out_last_d     = out_last_q;
    out_trunc_d    = out_trunc_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (in_req.op == OP_QUERY)) begin
          node_d  = in_req.query_node[NODE_W-1:0];
          addr_d  = '0;
          pend_d  = 1'b0;
          total_d = '0;
          trunc_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tri_hit) begin
          tri_d    = rd_data;
          corner_d = 2'd0;
          pend_d   = 1'b0;
          state_d  = S_CHECK;
        end else if (addr_q < limit_q) begin
          addr_d = addr_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d  = 1'b0;
          emit_d  = '0;
          state_d = S_EMIT;
        end
      end
      S_CHECK: begin
        self_d  = (cur_v == node_q);
        state_d = S_APPEND;
      end
      S_APPEND: begin
        // Append a corner that is neither the queried node nor yet listed, or flag the overflow.
        if (is_new) begin
          if (total_q < TOT_W'(MAX_NEIGHBORS)) begin
            list_d[total_q[LIST_IW-1:0]] = cur_v;
            total_d = total_q + 1'b1;
          end else begin
            trunc_d = 1'b1;
          end
        end
        if (corner_q == 2'd2) begin
          state_d = S_SCAN;
        end else begin
          corner_d = corner_q + 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = emit_final;
          if (total_q == '0) begin
            out_neighbor_d = '0;
            out_found_d    = 1'b0;
            out_trunc_d    = 1'b0;
          end else begin
            out_neighbor_d = NODE_FIELD_W'(list_q[emit_q[LIST_IW-1:0]]);
            out_found_d    = 1'b1;
            out_trunc_d    = trunc_q;
          end
          if (emit_final) begin
            state_d = S_IDLE;
          end else begin
            emit_d = emit_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      limit_q     <= '0;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      corner_q    <= '0;
      total_q     <= '0;
      trunc_q     <= 1'b0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      limit_q     <= (state_q == S_IDLE) ? limit_d : limit_q;
      addr_q      <= addr_d;
      pend_q      <= pend_d;
      corner_q    <= corner_d;
      total_q     <= total_d;
      trunc_q     <= trunc_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    node_q         <= node_d;
    tri_q          <= tri_d;
    dup_q          <= dup_d;
    self_q         <= self_d;
    list_q         <= list_d;
    out_neighbor_q <= out_neighbor_d;
    out_found_q    <= out_found_d;
    out_last_q     <= out_last_d;
    out_trunc_q    <= out_trunc_d;
  end

  // Result channel.
  assign out_rsp.valid     = out_valid_q;
  assign out_rsp.neighbor  = out_neighbor_q;
  assign out_rsp.found     = out_found_q;
  assign out_rsp.last      = out_last_q;
  assign out_rsp.truncated = out_trunc_q;

  // Checks.
  `MNNF_ASSERT(a_total_bound, total_q <= TOT_W'(MAX_NEIGHBORS), "neighbour count overflow")
  `MNNF_ASSERT_NEXT(a_query_starts, in_acc && (in_req.op == OP_QUERY),
                    state_q == S_SCAN && total_q == '0, "query did not start a scan")
  `MNNF_ASSERT_NEXT(a_triangle_done, state_q == S_APPEND && corner_q == 2'd2,
                    state_q == S_SCAN && !pend_q, "scan resumed with a stale read")
  `MNNF_ASSERT_IMP(a_empty_result, out_valid_q && !out_found_q,
                   out_last_q && !out_trunc_q && out_neighbor_q == '0,
                   "empty result is not a lone final result")
endmodule

FILE: tb/mesh_node_neighbor_finder_top_tb.sv
// ============================================================================
// Mesh node neighbour finder testbench
// Loads triangles into the table, sets the scanned triangle count and sends
// neighbour queries. A scoreboard predicts each result list and checks the
// results as they leave the block. Both channels idle and stall at random.
// ============================================================================
`timescale 1ns / 1ps

module mesh_node_neighbor_finder_top_tb;
  import mnnf_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned SETTLE_CYCLES  = 8;
  // The longest correct silence is a query over the largest count used here
  // (64) in which every triangle holds the node, plus the longest request gap
  // or result stall.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned NODE_POOL      = 24;
  localparam int unsigned SEG_COUNT      = 6;
  localparam int unsigned SEG_ITEMS      = 12;

  typedef struct packed {
    logic                    op;
    logic [SLOT_W-1:0]       slot;
    logic [NODE_FIELD_W-1:0] corner_a;
    logic [NODE_FIELD_W-1:0] corner_b;
    logic [NODE_FIELD_W-1:0] corner_c;
    logic [NODE_FIELD_W-1:0] query_node;
  } mesh_req_t;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0] neighbor;
    logic                    found;
    logic                    last;
    logic                    truncated;
  } neighbor_rsp_t;

  // Keeps its own triangle table and count, and the neighbour lists owed.
  class neighbor_scoreboard;
    bit [3*NODE_FIELD_W-1:0] triangles [MAX_TRIANGLES_DEF];
    bit [COUNT_W-1:0]        scan_count;
    neighbor_rsp_t           owed_q [$];
    int unsigned             error_count;

    function void set_count(input bit [COUNT_W-1:0] value);
      scan_count = value;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Queues one owed result behind those already owed.
    function void owe(input neighbor_rsp_t rsp);
      owed_q = {owed_q, rsp};
    endfunction

    // Applies an accepted request and queues the results that it causes.
    function void note_request(input mesh_req_t req);
      int unsigned             scan;
      int unsigned             total;
      bit                      trunc;
      bit                      dup;
      bit [NODE_FIELD_W-1:0]   corner [3];
      bit [NODE_FIELD_W-1:0]   adjacent [MAX_NEIGHBORS_DEF];
      neighbor_rsp_t           rsp;
      if (req.op == OP_LOAD) begin
        triangles[req.slot] = {req.corner_a, req.corner_b, req.corner_c};
        return;
      end
      scan  = (scan_count > MAX_TRIANGLES_DEF) ? MAX_TRIANGLES_DEF : scan_count;
      total = 0;
      trunc = 1'b0;
      for (int unsigned t = 0; t < scan; t++) begin
        {corner[0], corner[1], corner[2]} = triangles[t];
        if (corner[0] != req.query_node && corner[1] != req.query_node &&
            corner[2] != req.query_node) begin
          continue;
        end
        for (int k = 0; k < 3; k++) begin
          if (corner[k] == req.query_node) begin
            continue;
          end
          dup = 1'b0;
          for (int unsigned i = 0; i < total; i++) begin
            if (adjacent[i] == corner[k]) begin
              dup = 1'b1;
            end
          end
          if (dup) begin
            continue;
          end
          if (total < MAX_NEIGHBORS_DEF) begin
            adjacent[total] = corner[k];
            total++;
          end else begin
            trunc = 1'b1;
          end
        end
      end
      // A node without neighbours still gets one closing result.
      if (total == 0) begin
        rsp = '{neighbor: '0, found: 1'b0, last: 1'b1, truncated: 1'b0};
        owe(rsp);
        return;
      end
      for (int unsigned k = 0; k < total; k++) begin
        rsp = '{neighbor: adjacent[k], found: 1'b1, last: (k + 1 == total),
                truncated: trunc};
        owe(rsp);
      end
    endfunction

    // Compares one accepted result with the oldest owed one.
    function void check_result(input logic [NODE_FIELD_W-1:0] neighbor,
                               input logic found, input logic last,
                               input logic truncated);
      neighbor_rsp_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result: neighbor %0h found %0b last %0b truncated %0b",
               neighbor, found, last, truncated);
        error_count++;
        return;
      end
      want = owed_q.pop_front();
      if (neighbor !== want.neighbor) begin
        $error("neighbor: expected %0h, actual %0h", want.neighbor, neighbor);
        error_count++;
      end
      if (found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, found);
        error_count++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        error_count++;
      end
      if (truncated !== want.truncated) begin
        $error("truncated: expected %0b, actual %0b", want.truncated, truncated);
        error_count++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [COUNT_W-1:0]  cfg_data_i;

  mnnf_in_if  in_req ();
  mnnf_out_if out_rsp ();

  neighbor_scoreboard  sb;
  bit                  slot_loaded [MAX_TRIANGLES_DEF];
  bit                  idle_en;
  int unsigned         idle_odds;
  int unsigned         stall_left;
  int unsigned         silent_cycles;

  mesh_node_neighbor_finder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req     (in_req),
    .out_rsp    (out_rsp),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Mostly a small pool so that triangles share nodes, sometimes any node or an extreme value.
  function automatic logic [NODE_FIELD_W-1:0] pick_node(input int unsigned pool);
    int unsigned           roll;
    logic [NODE_FIELD_W-1:0] node;
    roll = $urandom_range(0, 9);
    if (roll < 8) begin
      node = NODE_FIELD_W'($urandom_range(0, pool - 1));
    end else if (roll == 8) begin
      node = NODE_FIELD_W'($urandom);
    end else begin
      node = ($urandom_range(0, 1) != 0) ? '1 : '0;
    end
    return node;
  endfunction

  // Presents one request, after an optional gap, and waits for its acceptance.
  // Valid stays high between back-to-back requests.
  task automatic send_request(input mesh_req_t req);
    int unsigned gap;
    if (idle_en && $urandom_range(0, idle_odds - 1) == 0) begin
      gap = $urandom_range(1, 15);
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req.valid      <= 1'b1;
    in_req.op         <= req.op;
    in_req.slot       <= req.slot;
    in_req.corner_a   <= req.corner_a;
    in_req.corner_b   <= req.corner_b;
    in_req.corner_c   <= req.corner_c;
    in_req.query_node <= req.query_node;
    if (req.op == OP_LOAD) begin
      slot_loaded[req.slot] = 1'b1;
    end
    @(posedge clk_i);
    while (!in_req.ready) @(posedge clk_i);
    sb.note_request(req);
  endtask

  // Unused fields carry random values so that every bit moves.
  task automatic send_load(input logic [SLOT_W-1:0] slot,
                           input logic [NODE_FIELD_W-1:0] a,
                           input logic [NODE_FIELD_W-1:0] b,
                           input logic [NODE_FIELD_W-1:0] c);
    mesh_req_t req;
    req = '{op: OP_LOAD, slot: slot, corner_a: a, corner_b: b, corner_c: c,
            query_node: NODE_FIELD_W'($urandom)};
    send_request(req);
  endtask

  task automatic send_query(input logic [NODE_FIELD_W-1:0] node);
    mesh_req_t req;
    req = '{op: OP_QUERY, slot: SLOT_W'($urandom), corner_a: NODE_FIELD_W'($urandom),
            corner_b: NODE_FIELD_W'($urandom), corner_c: NODE_FIELD_W'($urandom),
            query_node: node};
    send_request(req);
  endtask

  // Lowers valid and waits until every owed result has arrived.
  task automatic drain();
    in_req.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_count(value);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Loads every slot below the count that has not been loaded yet, so that a
  // query never scans an unwritten slot.
  task automatic fill_slots(input int unsigned count, input int unsigned pool);
    int unsigned cap;
    cap = (count > MAX_TRIANGLES_DEF) ? MAX_TRIANGLES_DEF : count;
    for (int unsigned s = 0; s < cap; s++) begin
      if (!slot_loaded[s]) begin
        send_load(SLOT_W'(s), pick_node(pool), pick_node(pool), pick_node(pool));
      end
    end
  endtask

  // Result side: checks accepted results and stalls in random bursts.
  initial begin
    out_rsp.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_rsp.valid && out_rsp.ready) begin
          sb.check_result(out_rsp.neighbor, out_rsp.found, out_rsp.last,
                          out_rsp.truncated);
        end
        if (stall_left > 0) begin
          out_rsp.ready <= 1'b0;
          stall_left--;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(0, 14);
          out_rsp.ready <= 1'b0;
        end else begin
          out_rsp.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
          cfg_we_i) begin
        silent_cycles <= 0;
      end else if (silent_cycles >= WATCHDOG_LIMIT) begin
        $display("mesh_node_neighbor_finder_top_tb: done, errors");
        $finish;
      end else begin
        silent_cycles <= silent_cycles + 1;
      end
    end else begin
      silent_cycles <= 0;
    end
  end

  // Request side and run control.
  initial begin
    int unsigned             cap;
    int unsigned             count;
    logic [SLOT_W-1:0]       slot;
    logic [NODE_FIELD_W-1:0] a;
    logic [NODE_FIELD_W-1:0] c;
    sb = new;
    idle_en   = 1'b1;
    idle_odds = 4;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_data_i        <= '0;
    in_req.valid      <= 1'b0;
    in_req.op         <= OP_LOAD;
    in_req.slot       <= '0;
    in_req.corner_a   <= '0;
    in_req.corner_b   <= '0;
    in_req.corner_c   <= '0;
    in_req.query_node <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The count is zero after reset, so nothing is scanned.
    send_query('1);

    // A small mesh with a shared edge, a degenerate triangle and the extreme
    // node values, plus the highest slot.
    send_load(SLOT_W'(0), 16'd1, 16'd2, 16'd3);
    send_load(SLOT_W'(1), 16'd3, 16'd4, 16'd1);
    send_load(SLOT_W'(2), 16'd5, 16'd5, 16'd7);
    send_load(SLOT_W'(3), 16'hFFFF, 16'h0000, 16'd5);
    send_load('1, 16'hAAAA, 16'h5555, 16'hFFFF);
    drain();
    write_count(COUNT_W'(4));
    send_query(16'd1);
    send_query(16'd5);
    send_query(16'h0000);
    send_query(16'd9);
    send_query(16'hFFFF);

    // Nine triangles around one node give more neighbours than the list holds.
    for (int k = 0; k < 9; k++) begin
      a = NODE_FIELD_W'(32'h2000 + 2 * k);
      c = NODE_FIELD_W'(32'h2001 + 2 * k);
      case (k % 3)
        0: begin
          send_load(SLOT_W'(4 + k), 16'h1234, a, c);
        end
        1: begin
          send_load(SLOT_W'(4 + k), a, 16'h1234, c);
        end
        default: begin
          send_load(SLOT_W'(4 + k), a, c, 16'h1234);
        end
      endcase
    end
    drain();
    write_count(COUNT_W'(13));
    send_query(16'h1234);
    send_query(16'd3);

    // Random phases, each with its own count and idling mix.
    for (int unsigned seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg)
        0: count = $urandom_range(1, 8);
        1: count = 0;
        2: count = $urandom_range(24, 48);
        3: count = 1;
        4: count = $urandom_range(2, 20);
        default: count = $urandom_range(40, 64);
      endcase
      idle_en   = (seg != 3);
      idle_odds = (seg % 2 == 0) ? 4 : 2;
      drain();
      write_count(COUNT_W'(count));
      fill_slots(count, NODE_POOL);
      cap = count;
      for (int unsigned n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 45) begin
          if ($urandom_range(0, 4) == 0) begin
            slot = SLOT_W'($urandom_range(0, MAX_TRIANGLES_DEF - 1));
          end else begin
            slot = SLOT_W'($urandom_range(0, cap + 3));
          end
          a = pick_node(NODE_POOL);
          c = ($urandom_range(0, 9) == 0) ? a : pick_node(NODE_POOL);
          send_load(slot, a, pick_node(NODE_POOL), c);
        end else begin
          send_query(pick_node(NODE_POOL));
        end
      end
    end

    // Last part, without idling: queries back to back over the last count.
    idle_en = 1'b0;
    drain();
    repeat (6) send_query(pick_node(NODE_POOL));
    drain();

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("mesh_node_neighbor_finder_top_tb: done, clean");
    end else begin
      $display("mesh_node_neighbor_finder_top_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: mesh_node_neighbor_finder_top.f
+incdir+design
design/mnnf_pkg.sv
design/mnnf_in_if.sv
design/mnnf_out_if.sv
design/mnnf_ram.sv
design/mesh_node_neighbor_finder_top.sv
tb/mesh_node_neighbor_finder_top_tb.sv
